### sv/ptss_pkg.sv
// Package for the per-thread state stack: widths, codes and state type.
package ptss_pkg;

    localparam int unsigned THREADS_DEF     = 64;
    localparam int unsigned STACK_DEPTH_DEF = 32;

    localparam int unsigned CMD_W       = 3;
    localparam int unsigned TID_W       = 6;
    localparam int unsigned CODE_W      = 8;
    localparam int unsigned DEPTH_OUT_W = 6;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [CODE_W-1:0] IDLE_CODE_RST        = 8'd0;
    localparam logic [CODE_W-1:0] NOT_TRACING_CODE_RST = 8'd255;
    localparam logic [CODE_W-1:0] WILDCARD_CODE_RST    = 8'd254;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH      = 3'd0,
        CMD_POP       = 3'd1,
        CMD_POP_UNTIL = 3'd2,
        CMD_TOP       = 3'd3,
        CMD_CLEAR     = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IDLE_CODE        = 2'd0,
        REG_NOT_TRACING_CODE = 2'd1,
        REG_WILDCARD_CODE    = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_DEPTH,
        S_LOOK
    } state_t;

endpackage

### sv/per_thread_state_stack_unit.sv
// Top level of the per-thread state stack: depth memory, stack memory and sequencer.
//
//  Channel   | Signals                                         | Direction
//  ----------+-------------------------------------------------+----------
//  request   | req_valid, req_ready, cmd, thread_id,           | in
//            | state_value                                     |
//  result    | res_valid, res_ready, result_state, depth_after,| out
//            | removed, overflow                               |
//  config    | cfg_write_en, cfg_index, cfg_data               | in
//
// The accept edge reads the thread's depth, the depth state then reads the top entry
// at that depth, and the look-up state decides and writes back.
// A pop that first discards a not-tracing top needs another look-up, and pop-until
// needs another for every entry it removes; each is a dependent stack read.
// After reset the depth memory is cleared one thread per cycle, every thread in turn,
// and no request is accepted during that pass; configuration writes still land.
// The result sits in an output register, so a new request is taken while it waits;
// only the final write-back stalls when the previous result has not been taken.
module per_thread_state_stack_unit #(
    parameter int unsigned THREADS     = ptss_pkg::THREADS_DEF,
    parameter int unsigned STACK_DEPTH = ptss_pkg::STACK_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [ptss_pkg::CMD_W-1:0]        cmd,
    input  logic [ptss_pkg::TID_W-1:0]        thread_id,
    input  logic [ptss_pkg::CODE_W-1:0]       state_value,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [ptss_pkg::CODE_W-1:0]       result_state,
    output logic [ptss_pkg::DEPTH_OUT_W-1:0]  depth_after,
    output logic                              removed,
    output logic                              overflow,
    input  logic                              cfg_write_en,
    input  logic [ptss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptss_pkg::CODE_W-1:0]       cfg_data
);
    import ptss_pkg::*;

    // Thread index width, depth count width and stack memory address width.
    localparam int unsigned TW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(THREADS * STACK_DEPTH);

    // Configuration registers.
    logic [CODE_W-1:0] idle_code_reg;
    logic [CODE_W-1:0] nt_code_reg;
    logic [CODE_W-1:0] wild_code_reg;

    // Sequencer control.
    state_t            state_reg, state_next;
    logic [TW-1:0]     clr_reg, clr_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic              drop_reg, drop_next;

    // Captured request.
    logic [CMD_W-1:0]  cmd_reg;
    logic [CODE_W-1:0] val_reg;
    logic [TW-1:0]     thread_reg;
    logic [AW-1:0]     base_reg;

    // Result register.
    logic                   res_valid_reg, res_valid_next;
    logic [CODE_W-1:0]      result_reg, result_next;
    logic [DEPTH_OUT_W-1:0] depth_out_reg, depth_out_next;
    logic                   removed_reg, removed_next;
    logic                   overflow_reg, overflow_next;

    // Memories: per-thread depth and the stack entries of all threads.
    logic [DW-1:0]     depth_mem [THREADS];
    logic [CODE_W-1:0] stack_mem [THREADS*STACK_DEPTH];

    logic              d_re, d_we;
    logic [TW-1:0]     d_ra, d_wa;
    logic [DW-1:0]     d_wd, d_q;
    logic              st_re, st_we;
    logic [AW-1:0]     st_ra, st_wa;
    logic [CODE_W-1:0] st_q;

    // Decode helpers.
    logic              req_fire;
    logic              out_free;
    logic [TW-1:0]     tid_mod;
    logic [AW-1:0]     base_calc;
    logic [CODE_W-1:0] top_cur;
    logic              top_is_nt;
    logic              look_done;
    logic              pop_match;
    logic [DW-1:0]     depth_fin;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign out_free  = !res_valid_reg || res_ready;

    // The thread index wrapped by the thread count, as a constant table over every
    // index the port can carry.
    always_comb
    begin
        tid_mod = '0;
        for (int i = 0; i < (1 << TID_W); i++)
        begin
            if (thread_id == TID_W'(i))
            begin
                tid_mod = TW'(i % THREADS);
            end
        end
    end

    assign base_calc = AW'(tid_mod) * AW'(STACK_DEPTH);

    // An empty stack reads as the idle code; otherwise the entry just read is the top.
    assign top_cur   = (depth_reg == '0) ? idle_code_reg : st_q;
    assign top_is_nt = (depth_reg != '0) && (top_cur == nt_code_reg);
    assign pop_match = (val_reg == wild_code_reg) || (top_cur == val_reg);

    // Whether the request finishes in this look-up cycle or needs another stack read.
    always_comb
    begin
        case (cmd_reg)
            CMD_POP:       look_done = drop_reg || !top_is_nt;
            CMD_POP_UNTIL: look_done = (top_cur == val_reg) || (depth_reg == '0);
            default:       look_done = 1'b1;
        endcase
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_code_reg <= IDLE_CODE_RST;
            nt_code_reg   <= NOT_TRACING_CODE_RST;
            wild_code_reg <= WILDCARD_CODE_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_IDLE_CODE:        idle_code_reg <= cfg_data;
                REG_NOT_TRACING_CODE: nt_code_reg   <= cfg_data;
                REG_WILDCARD_CODE:    wild_code_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (clr_reg == TW'(THREADS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_DEPTH;
                end
            end
            S_DEPTH:
            begin
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (look_done && out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // Memory controls and register updates.
    always_comb
    begin
        clr_next       = clr_reg;
        depth_next     = depth_reg;
        drop_next      = drop_reg;
        res_valid_next = res_valid_reg && !res_ready;
        result_next    = result_reg;
        depth_out_next = depth_out_reg;
        removed_next   = removed_reg;
        overflow_next  = overflow_reg;
        depth_fin      = depth_reg;
        d_re  = 1'b0;
        d_ra  = tid_mod;
        d_we  = 1'b0;
        d_wa  = thread_reg;
        d_wd  = depth_reg;
        st_re = 1'b0;
        st_ra = base_reg;
        st_we = 1'b0;
        st_wa = base_reg;
        case (state_reg)
            S_INIT:
            begin
                d_we     = 1'b1;
                d_wa     = clr_reg;
                d_wd     = '0;
                clr_next = clr_reg + TW'(1);
            end
            S_IDLE:
            begin
                d_re = req_fire;
            end
            S_DEPTH:
            begin
                depth_next = d_q;
                drop_next  = 1'b0;
                st_re      = (d_q != '0);
                st_ra      = AW'(base_reg + AW'(d_q) - AW'(1));
            end
            S_LOOK:
            begin
                if (!look_done)
                begin
                    // Discard a not-tracing top, or one pop-until step, then read again.
                    depth_next = depth_reg - DW'(1);
                    drop_next  = 1'b1;
                    st_re      = (depth_reg > DW'(1));
                    st_ra      = AW'(base_reg + AW'(depth_reg) - AW'(2));
                end
                else if (out_free)
                begin
                    res_valid_next = 1'b1;
                    removed_next   = 1'b0;
                    overflow_next  = 1'b0;
                    result_next    = top_cur;
                    case (cmd_reg)
                        CMD_PUSH:
                        begin
                            if (top_is_nt)
                            begin
                                // The new code takes the slot of the discarded one.
                                st_we       = 1'b1;
                                st_wa       = AW'(base_reg + AW'(depth_reg) - AW'(1));
                                result_next = val_reg;
                            end
                            else if (depth_reg >= DW'(STACK_DEPTH))
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                st_we       = 1'b1;
                                st_wa       = AW'(base_reg + AW'(depth_reg));
                                depth_fin   = depth_reg + DW'(1);
                                result_next = val_reg;
                            end
                        end
                        CMD_POP:
                        begin
                            if (pop_match && (depth_reg != '0))
                            begin
                                depth_fin    = depth_reg - DW'(1);
                                removed_next = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            depth_fin   = '0;
                            result_next = idle_code_reg;
                        end
                        default:
                        begin
                            depth_fin = depth_reg;
                        end
                    endcase
                    d_we           = 1'b1;
                    d_wd           = depth_fin;
                    depth_out_next = DEPTH_OUT_W'(depth_fin);
                end
            end
            default:
            begin
                clr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_reg       <= '0;
            depth_reg     <= '0;
            drop_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            depth_reg     <= depth_next;
            drop_reg      <= drop_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Request capture and result payload.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg    <= cmd;
            val_reg    <= state_value;
            thread_reg <= tid_mod;
            base_reg   <= base_calc;
        end
        result_reg    <= result_next;
        depth_out_reg <= depth_out_next;
        removed_reg   <= removed_next;
        overflow_reg  <= overflow_next;
    end

    // Depth memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            depth_mem[d_wa] <= d_wd;
        end
        if (d_re)
        begin
            d_q <= depth_mem[d_ra];
        end
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stack_mem[st_wa] <= val_reg;
        end
        if (st_re)
        begin
            st_q <= stack_mem[st_ra];
        end
    end

    assign res_valid    = res_valid_reg;
    assign result_state = result_reg;
    assign depth_after  = depth_out_reg;
    assign removed      = removed_reg;
    assign overflow     = overflow_reg;

    // A stack never grows past its capacity.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |-> (depth_reg <= DW'(STACK_DEPTH)))
        else $error("stack depth beyond capacity");

    // An accepted request always goes on to the depth look-up.
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_DEPTH))
        else $error("accepted request did not start a depth read");

    // A new result appears only when a look-up cycle finishes.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_LOOK))
        else $error("result raised outside the look-up state");

    // Stack entries are written only while a request finishes.
    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> ((state_reg == S_LOOK) && look_done && out_free))
        else $error("stack write outside a finishing request");

    // Removed and overflow never flag together.
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(removed_reg && overflow_reg))
        else $error("removed and overflow both set");

endmodule
